### hw/rtl/pidaw_pkg.sv
`timescale 1ns / 1ps

package pidaw_pkg;

	localparam int GAIN_W     = 32;
	localparam int TRACK_W    = 32;
	localparam int DIGIT_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [TRACK_W-1:0] TRACK_MAX = {1'b0, {(TRACK_W-1){1'b1}}};
	localparam logic signed [TRACK_W-1:0] TRACK_MIN = {1'b1, {(TRACK_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_GAIN_TRACK,
		REG_SETPOINT,
		REG_OUT_MIN,
		REG_OUT_MAX,
		REG_INVERT
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_GO,
		ST_P_WAIT,
		ST_D_GO,
		ST_D_WAIT,
		ST_CLAMP,
		ST_DIFF,
		ST_T_GO,
		ST_T_WAIT,
		ST_I_GO,
		ST_I_WAIT,
		ST_ICLAMP,
		ST_DONE
	} state_t;

endpackage

### hw/rtl/pidaw_if.sv
`timescale 1ns / 1ps

interface pidaw_sample_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] measurement;

	modport source (output valid, output measurement, input ready);
	modport sink (input valid, input measurement, output ready);
endinterface

interface pidaw_control_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] drive;
	logic                          clamped;

	modport source (output valid, output drive, output clamped, input ready);
	modport sink (input valid, input drive, input clamped, output ready);
endinterface

interface pidaw_cfg_if import pidaw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pidaw_mul.sv
`timescale 1ns / 1ps

module pidaw_mul import pidaw_pkg::*; #(
	parameter int OPD_W  = 32,
	parameter int PROD_W = 67
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [GAIN_W-1:0] gain,
	input  logic signed [OPD_W-1:0]  opd,
	output logic                     done,
	output logic signed [PROD_W-1:0] prod
);

	localparam int NDIG  = (OPD_W + DIGIT_W - 1) / DIGIT_W;
	localparam int LOW_W = NDIG * DIGIT_W;
	localparam int ACC_W = GAIN_W + DIGIT_W + 1;
	localparam int CNT_W = $clog2(NDIG + 1);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [GAIN_W-1:0] gain_q;
	logic [LOW_W-1:0]         opd_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [LOW_W-1:0]         low_q;

	logic                     last;
	logic [DIGIT_W-1:0]       dig;
	logic signed [DIGIT_W:0]  dig_s;
	logic signed [ACC_W-1:0]  pp;
	logic signed [ACC_W-1:0]  sum;

	assign last  = cnt_q == CNT_W'(NDIG - 1);
	assign dig   = opd_q[DIGIT_W-1:0];
	// top digit carries the operand sign, all others are unsigned
	assign dig_s = last ? {dig[DIGIT_W-1], dig} : {1'b0, dig};
	assign pp    = gain_q * dig_s;
	assign sum   = acc_q + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gain_q <= gain;
			opd_q  <= LOW_W'(opd);
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q <= sum >>> DIGIT_W;
			low_q <= {sum[DIGIT_W-1:0], low_q[LOW_W-1:DIGIT_W]};
			opd_q <= opd_q >> DIGIT_W;
		end
	end

	assign done = done_q;
	assign prod = PROD_W'($signed({acc_q, low_q}));

endmodule

### hw/rtl/pid_controller_antiwindup.sv
`timescale 1ns / 1ps

// PID regulator with tracking anti-windup. Each measurement beat yields one drive beat.
// One shared digit-serial multiplier (4 bits of the operand per cycle) forms the four
// products of a sample in turn: Kp*e, Kd*dy, Ktrack*(u-v) and Ki*e, each over
// N = ceil(max(SAMPLE_BITS+1, 32) / 4) operand digits. The drive is loaded after the
// fourth product and the integral clamp, and the next sample can be taken in the cycle
// after the load. The result sits in an output register, so a new sample is taken
// while the previous drive still waits; a sample only stalls when its own drive is
// ready and the previous one has not been taken.
// Configuration writes are accepted at any cycle and take effect at once.
module pid_controller_antiwindup import pidaw_pkg::*; #(
	parameter int SAMPLE_BITS    = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input logic               clk,
	input logic               arst_n,
	pidaw_sample_if.sink      sample,
	pidaw_control_if.source   control,
	pidaw_cfg_if.sink         cfg
);

	localparam int EW    = SAMPLE_BITS + 1;
	localparam int LW    = SAMPLE_BITS + GAIN_FRAC_BITS;
	localparam int OPD_W = (EW > TRACK_W) ? EW : TRACK_W;
	localparam int AW    = GAIN_W + OPD_W + 3;

	state_t state_q, state_nxt;

	logic signed [GAIN_W-1:0]      gain_p_q, gain_i_q, gain_d_q, gain_track_q;
	logic signed [SAMPLE_BITS-1:0] setpoint_q, out_min_q, out_max_q;
	logic                          invert_q;

	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [LW-1:0]          integral_q;

	logic signed [EW-1:0]      e_q, dy_q;
	logic signed [AW-1:0]      acc_q;
	logic signed [LW-1:0]      u_q;
	logic                      clamped_q;
	logic signed [TRACK_W-1:0] d_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] drive_q;
	logic                          clamp_out_q;

	logic in_ready, mul_start, out_free, out_load;
	logic signed [GAIN_W-1:0] mul_gain;
	logic signed [OPD_W-1:0]  mul_opd;
	logic                     mul_done;
	logic signed [AW-1:0]     mul_prod;

	logic signed [EW-1:0] err_raw, err, dmeas;
	logic signed [LW-1:0] lo, hi;
	logic signed [AW-1:0] lo_a, hi_a, diff;
	logic                 below, above, diff_pos_ovf, diff_neg_ovf;
	logic signed [LW-1:0] clamp_val;
	logic                 in_beat;

	assign in_beat = sample.valid && in_ready;

	assign err_raw = EW'(setpoint_q) - EW'(sample.measurement);
	assign err     = invert_q ? -err_raw : err_raw;
	assign dmeas   = EW'(sample.measurement) - EW'(prev_q);

	assign lo   = {out_min_q, {GAIN_FRAC_BITS{1'b0}}};
	assign hi   = {out_max_q, {GAIN_FRAC_BITS{1'b0}}};
	assign lo_a = AW'(lo);
	assign hi_a = AW'(hi);

	// crossed limits: anything not below out_min goes to out_max
	assign below     = acc_q < lo_a;
	assign above     = acc_q > hi_a;
	assign clamp_val = below ? lo : (above ? hi : acc_q[LW-1:0]);

	assign diff         = AW'(u_q) - acc_q;
	assign diff_pos_ovf = !diff[AW-1] && (|diff[AW-2:TRACK_W-1]);
	assign diff_neg_ovf = diff[AW-1] && !(&diff[AW-2:TRACK_W-1]);

	assign out_free = !out_valid_q || control.ready;
	assign out_load = (state_q == ST_DONE) && out_free;

	pidaw_mul #(
		.OPD_W  (OPD_W),
		.PROD_W (AW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.gain   (mul_gain),
		.opd    (mul_opd),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			gain_track_q <= '0;
			setpoint_q   <= '0;
			out_min_q    <= '0;
			out_max_q    <= '0;
			invert_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_GAIN_P:     gain_p_q     <= cfg.data[GAIN_W-1:0];
				REG_GAIN_I:     gain_i_q     <= cfg.data[GAIN_W-1:0];
				REG_GAIN_D:     gain_d_q     <= cfg.data[GAIN_W-1:0];
				REG_GAIN_TRACK: gain_track_q <= cfg.data[GAIN_W-1:0];
				REG_SETPOINT:   setpoint_q   <= cfg.data[SAMPLE_BITS-1:0];
				REG_OUT_MIN:    out_min_q    <= cfg.data[SAMPLE_BITS-1:0];
				REG_OUT_MAX:    out_max_q    <= cfg.data[SAMPLE_BITS-1:0];
				REG_INVERT:     invert_q     <= cfg.data[0];
			endcase
		end
	end

	// sequencer
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_beat) state_nxt = ST_P_GO;
			ST_P_GO:   state_nxt = ST_P_WAIT;
			ST_P_WAIT: if (mul_done) state_nxt = ST_D_GO;
			ST_D_GO:   state_nxt = ST_D_WAIT;
			ST_D_WAIT: if (mul_done) state_nxt = ST_CLAMP;
			ST_CLAMP:  state_nxt = ST_DIFF;
			ST_DIFF:   state_nxt = ST_T_GO;
			ST_T_GO:   state_nxt = ST_T_WAIT;
			ST_T_WAIT: if (mul_done) state_nxt = ST_I_GO;
			ST_I_GO:   state_nxt = ST_I_WAIT;
			ST_I_WAIT: if (mul_done) state_nxt = ST_ICLAMP;
			ST_ICLAMP: state_nxt = ST_DONE;
			ST_DONE:   if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mul_start = 1'b0;
		mul_gain  = gain_p_q;
		mul_opd   = OPD_W'(e_q);
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_P_GO: begin
				mul_start = 1'b1;
				mul_gain  = gain_p_q;
				mul_opd   = OPD_W'(e_q);
			end
			ST_D_GO: begin
				mul_start = 1'b1;
				mul_gain  = gain_d_q;
				mul_opd   = OPD_W'(dy_q);
			end
			ST_T_GO: begin
				mul_start = 1'b1;
				mul_gain  = gain_track_q;
				mul_opd   = OPD_W'(d_q);
			end
			ST_I_GO: begin
				mul_start = 1'b1;
				mul_gain  = gain_i_q;
				mul_opd   = OPD_W'(e_q);
			end
			default: begin
				in_ready  = 1'b0;
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			integral_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_beat) begin
				prev_q <= sample.measurement;
			end
			if (state_q == ST_ICLAMP) begin
				integral_q <= clamp_val;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (control.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_beat) begin
			e_q   <= err;
			dy_q  <= dmeas;
			acc_q <= AW'(integral_q);
		end
		unique case (state_q)
			ST_P_WAIT, ST_D_WAIT, ST_I_WAIT: begin
				if (mul_done) acc_q <= acc_q + mul_prod;
			end
			ST_T_WAIT: begin
				// tracking term rounds toward minus infinity, then starts the new integral
				if (mul_done) acc_q <= AW'(integral_q) + (mul_prod >>> GAIN_FRAC_BITS);
			end
			ST_CLAMP: begin
				u_q       <= clamp_val;
				clamped_q <= below || above;
			end
			ST_DIFF: begin
				priority if (diff_pos_ovf) d_q <= TRACK_MAX;
				else if (diff_neg_ovf) d_q <= TRACK_MIN;
				else d_q <= diff[TRACK_W-1:0];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			drive_q     <= u_q[LW-1:GAIN_FRAC_BITS];
			clamp_out_q <= clamped_q;
		end
	end

	assign sample.ready    = in_ready;
	assign control.valid   = out_valid_q;
	assign control.drive   = drive_q;
	assign control.clamped = clamp_out_q;

	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_P_WAIT || state_q == ST_D_WAIT ||
			state_q == ST_T_WAIT || state_q == ST_I_WAIT))
		else $error("multiplier finished outside a wait state");

	a_integral_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_min_q <= out_max_q) |->
			(integral_q >= lo && integral_q <= hi))
		else $error("integral outside drive limits after update");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !control.ready) |=> state_q == ST_DONE)
		else $error("result left while output register still occupied");

endmodule

### bench/tb_pid_controller_antiwindup.sv
`timescale 1ns / 1ps

module tb_pid_controller_antiwindup import pidaw_pkg::*; ();

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 100;

	typedef enum logic [1:0] {
		ACT_SAMPLE,
		ACT_WRITE,
		ACT_DRAIN,
		ACT_PACE
	} action_t;

	typedef struct {
		action_t            act;
		logic signed [15:0] meas;
		cfg_reg_t           idx;
		logic [31:0]        data;
		int unsigned        idle_pct;
		int unsigned        stall_pct;
	} plan_step_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               clamped;
	} control_t;

	logic clk = 1'b0;
	logic arst_n;

	pidaw_sample_if #(.SAMPLE_BITS(16)) smp ();
	pidaw_control_if #(.SAMPLE_BITS(16)) ctl ();
	pidaw_cfg_if cfg_ch ();

	pid_controller_antiwindup #(.SAMPLE_BITS(16), .GAIN_FRAC_BITS(16)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.control (ctl),
		.cfg     (cfg_ch)
	);

	plan_step_t  plan_q[$];
	control_t    drive_due_q[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int          mismatches = 0;
	int          cycle_count = 0;

	// regulator copy: registers and state
	logic signed [31:0] kp, ki, kd, kt;
	logic signed [15:0] sp, umin, umax;
	logic               inv;
	longint             integ;
	logic signed [15:0] last_meas;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint limit(input longint x, input longint lo, input longint hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	function automatic control_t regulate(input logic signed [15:0] y);
		longint   lo, hi, e, v, u, gap;
		control_t r;
		lo = longint'(umin) * 65536;
		hi = longint'(umax) * 65536;
		e = longint'(sp) - longint'(y);
		if (inv)
			e = -e;
		v = longint'(kp) * e + integ + longint'(kd) * (longint'(y) - longint'(last_meas));
		u = limit(v, lo, hi);
		r.drive = 16'(u >>> 16);
		r.clamped = (v < lo) || (v > hi);
		// tracking sees u - v saturated to 32 bits, product floored back to q16
		gap = limit(u - v, longint'(TRACK_MIN), longint'(TRACK_MAX));
		integ = limit(integ + longint'(ki) * e + ((longint'(kt) * gap) >>> 16), lo, hi);
		last_meas = y;
		return r;
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(9))
		0: return 32'd0;
		1: return 32'h7fff_ffff;
		2: return 32'h8000_0000;
		3, 4: return $urandom;
		default: return 32'(int'($urandom_range(524288)) - 262144);
		endcase
	endfunction

	task automatic plan(input action_t a, input logic signed [15:0] y, input cfg_reg_t r,
			input logic [31:0] d, input int unsigned idle, input int unsigned stall);
		plan_step_t s;
		s.act = a;
		s.meas = y;
		s.idx = r;
		s.data = d;
		s.idle_pct = idle;
		s.stall_pct = stall;
		plan_q.push_back(s);
	endtask

	task automatic plan_sample(input logic signed [15:0] y);
		plan(ACT_SAMPLE, y, REG_GAIN_P, '0, 0, 0);
	endtask

	// every register rewritten once the block has gone quiet
	task automatic plan_settings(input logic [31:0] p, i, d, t,
			input logic signed [15:0] s, lo, hi, input logic x);
		plan(ACT_DRAIN, '0, REG_GAIN_P, '0, 0, 0);
		plan(ACT_WRITE, '0, REG_GAIN_P, p, 0, 0);
		plan(ACT_WRITE, '0, REG_GAIN_I, i, 0, 0);
		plan(ACT_WRITE, '0, REG_GAIN_D, d, 0, 0);
		plan(ACT_WRITE, '0, REG_GAIN_TRACK, t, 0, 0);
		plan(ACT_WRITE, '0, REG_SETPOINT, {{16{s[15]}}, s}, 0, 0);
		plan(ACT_WRITE, '0, REG_OUT_MIN, {{16{lo[15]}}, lo}, 0, 0);
		plan(ACT_WRITE, '0, REG_OUT_MAX, {{16{hi[15]}}, hi}, 0, 0);
		plan(ACT_WRITE, '0, REG_INVERT, {31'd0, x}, 0, 0);
	endtask

	task automatic plan_random_phase(input int unsigned idle, input int unsigned stall);
		int                 count;
		int                 span;
		logic signed [15:0] a, b, set, lo, hi, y;
		count = 0;
		plan(ACT_PACE, '0, REG_GAIN_P, '0, idle, stall);
		while (count < 312) begin
			set = 16'($urandom);
			a = 16'($urandom);
			b = 16'($urandom);
			case ($urandom_range(9))
			0: begin
				lo = (a > b) ? a : b;
				hi = (a > b) ? b : a;
			end
			1: begin
				lo = 16'sh8000;
				hi = 16'sh7fff;
			end
			2: begin
				lo = a;
				hi = a;
			end
			default: begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
			endcase
			plan_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), set, lo, hi,
				1'($urandom));
			span = 1 << $urandom_range(12, 2);
			y = set;
			// mostly samples hovering round the setpoint so the integral moves both ways
			repeat ($urandom_range(50, 15)) begin
				case ($urandom_range(9))
				0: y = 16'($urandom);
				1, 2: y = 16'(limit(int'(y) + int'($urandom_range(span)) - span / 2,
					-32768, 32767));
				default: y = 16'(limit(int'(set) + int'($urandom_range(2 * span)) - span,
					-32768, 32767));
				endcase
				plan_sample(y);
				count++;
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
		if (mismatches < 10)
			$display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : sample_driver
		plan_step_t head;
		logic       s_go, c_go;
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.measurement <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= REG_GAIN_P;
			cfg_ch.data <= '0;
			send_idle_pct <= 0;
			recv_stall_pct <= 0;
		end else begin
			s_go = smp.valid && !smp.ready;
			c_go = cfg_ch.valid && !cfg_ch.ready;
			if (!s_go && !c_go && plan_q.size() != 0) begin
				head = plan_q[0];
				case (head.act)
				ACT_SAMPLE: begin
					if ($urandom_range(99) >= send_idle_pct) begin
						smp.measurement <= head.meas;
						s_go = 1'b1;
						void'(plan_q.pop_front());
					end
				end
				ACT_WRITE: begin
					cfg_ch.index <= head.idx;
					cfg_ch.data <= head.data;
					c_go = 1'b1;
					void'(plan_q.pop_front());
				end
				ACT_DRAIN: begin
					// a sample beat taken at this edge may not be predicted yet
					if (!smp.valid && drive_due_q.size() == 0)
						void'(plan_q.pop_front());
				end
				ACT_PACE: begin
					send_idle_pct <= head.idle_pct;
					recv_stall_pct <= head.stall_pct;
					void'(plan_q.pop_front());
				end
				endcase
			end
			smp.valid <= s_go;
			cfg_ch.valid <= c_go;
		end
	end

	always @(posedge clk or negedge arst_n) begin : control_monitor
		control_t due;
		if (!arst_n) begin
			ctl.ready <= 1'b0;
			kp = '0;
			ki = '0;
			kd = '0;
			kt = '0;
			sp = '0;
			umin = '0;
			umax = '0;
			inv = 1'b0;
			integ = 0;
			last_meas = '0;
		end else begin
			if (ctl.valid && ctl.ready) begin
				if (drive_due_q.size() == 0) begin
					flag_mismatch("unexpected drive beat", 0, ctl.drive);
				end else begin
					due = drive_due_q.pop_front();
					if (ctl.drive !== due.drive)
						flag_mismatch("drive", due.drive, ctl.drive);
					if (ctl.clamped !== due.clamped)
						flag_mismatch("clamped", due.clamped, ctl.clamped);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_reg_t'(cfg_ch.index))
				REG_GAIN_P:     kp = cfg_ch.data;
				REG_GAIN_I:     ki = cfg_ch.data;
				REG_GAIN_D:     kd = cfg_ch.data;
				REG_GAIN_TRACK: kt = cfg_ch.data;
				REG_SETPOINT:   sp = cfg_ch.data[15:0];
				REG_OUT_MIN:    umin = cfg_ch.data[15:0];
				REG_OUT_MAX:    umax = cfg_ch.data[15:0];
				REG_INVERT:     inv = cfg_ch.data[0];
				default: ;
				endcase
			end
			if (smp.valid && smp.ready)
				drive_due_q.push_back(regulate(smp.measurement));
			ctl.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;

		// registers still at reset: zero gains, both limits zero
		plan_sample(16'sd1234);

		// moderate gains, output swings into both limits
		plan_settings(32'h0001_0000, 32'h0000_4000, 32'hffff_8000, 32'h0000_8000,
			16'sd1000, -16'sd2000, 16'sd2000, 1'b0);
		plan_sample(16'sd1000);
		plan_sample(16'sd999);
		plan_sample(16'sd0);
		plan_sample(16'sh7fff);
		plan_sample(16'sh8000);
		plan_sample(16'sd1000);
		plan_sample(16'sd3000);
		plan_sample(-16'sd1);

		// extreme gains and full limits, reverse acting: tracking difference saturates
		plan_settings(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			16'sh8000, 16'sh8000, 16'sh7fff, 1'b1);
		plan_sample(16'sh7fff);
		plan_sample(16'sh8000);
		plan_sample(16'sd0);
		plan_sample(16'sh7fff);
		plan_sample(16'sh8000);

		// crossed limits
		plan_settings(32'h0002_0000, 32'h0001_0000, 32'h0000_0000, 32'h8000_0000,
			16'sd0, 16'sd100, -16'sd100, 1'b0);
		plan_sample(16'sd0);
		plan_sample(16'sd500);
		plan_sample(-16'sd500);
		plan_sample(16'sh7fff);

		// both limits equal, derivative at full scale
		plan_settings(32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000,
			16'sh7fff, 16'sd5, 16'sd5, 1'b1);
		plan_sample(16'sh8000);
		plan_sample(16'sh7fff);
		plan_sample(16'sd5);
		plan_sample(16'sd5);

		plan_random_phase(0, 0);
		plan_random_phase(46, 0);
		plan_random_phase(0, 46);
		plan_random_phase(25, 25);

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(posedge clk);
		while (plan_q.size() != 0 || smp.valid || cfg_ch.valid || drive_due_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && drive_due_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
